[rtl/tvs_pkg.sv]
// ----------------------------------------------------------------------------
// Trilinear volume sampler package
// Register indexes, item codes and reset values shared by the sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tvs_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned COMPS     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_X = 3'd0,
    REG_UPPER_X = 3'd1,
    REG_LOWER_Y = 3'd2,
    REG_UPPER_Y = 3'd3,
    REG_LOWER_Z = 3'd4,
    REG_UPPER_Z = 3'd5,
    REG_PAD     = 3'd6,
    REG_FLAT    = 3'd7
  } cfg_reg_t;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic signed [WORD_W-1:0] RST_LOWER = 16'sd0;
  localparam logic signed [WORD_W-1:0] RST_UPPER = 16'sd16128;

endpackage

`default_nettype wire

[rtl/trilinear_volume_sampler.sv]
// ----------------------------------------------------------------------------
// Trilinear volume sampler
// Holds a voxel volume of intensity and gradients in eight parity banks and
// interpolates all four components at a fixed-point coordinate.
//
//   channel  | handshake          | payload
//   input    | in_valid/in_stall  | func, load_*, coord_*
//   output   | out_valid/out_stall| level_out, slope_x/y/z, inside_res
//   config   | cfg_we             | cfg_index, cfg_data
//
// One item is taken every cycle while in_stall is low. A sample result passes
// through the bank read, the x, y and z blends, then rounding into the output
// register. A load writes its bank at the beat and gives no result.
// Reset clears control and configuration only; the banks are not cleared.
// Stalls compress bubbles stage by stage; in_stall rises only when all stages
// and the output register are full and the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_volume_sampler #(
  parameter int DIM_X     = 64,
  parameter int DIM_Y     = 64,
  parameter int DIM_Z     = 64,
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               func,
  input  wire logic [5:0]         load_col,
  input  wire logic [5:0]         load_row,
  input  wire logic [5:0]         load_slice,
  input  wire logic signed [15:0] load_level,
  input  wire logic signed [15:0] load_grad_x,
  input  wire logic signed [15:0] load_grad_y,
  input  wire logic signed [15:0] load_grad_z,
  input  wire logic signed [15:0] coord_x,
  input  wire logic signed [15:0] coord_y,
  input  wire logic signed [15:0] coord_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      level_out,
  output logic signed [15:0]      slope_x,
  output logic signed [15:0]      slope_y,
  output logic signed [15:0]      slope_z,
  output logic                    inside_res,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int HXN = (DIM_X + 1) / 2;
  localparam int HYN = (DIM_Y + 1) / 2;
  localparam int HZN = (DIM_Z + 1) / 2;
  localparam int AXW = (HXN > 1) ? $clog2(HXN) : 1;
  localparam int AYW = (HYN > 1) ? $clog2(HYN) : 1;
  localparam int AZW = (HZN > 1) ? $clog2(HZN) : 1;
  localparam int AW  = AXW + AYW + AZW;
  localparam int DEPTH = 1 << AW;
  localparam int VW  = tvs_pkg::WORD_W;
  localparam int BW  = VW * tvs_pkg::COMPS;
  localparam int WX  = VW + FRAC_BITS;
  localparam int WY  = WX + FRAC_BITS;
  localparam int WZ  = WY + FRAC_BITS;
  localparam int SH  = 3 * FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [WZ:0] HALF = (WZ + 1)'(1) << (SH - 1);

  // Configuration registers.
  logic signed [15:0] lower_x, upper_x, lower_y, upper_y, lower_z, upper_z;
  logic signed [15:0] pad_value;
  logic               flat_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_x   <= tvs_pkg::RST_LOWER;
      upper_x   <= tvs_pkg::RST_UPPER;
      lower_y   <= tvs_pkg::RST_LOWER;
      upper_y   <= tvs_pkg::RST_UPPER;
      lower_z   <= tvs_pkg::RST_LOWER;
      upper_z   <= tvs_pkg::RST_UPPER;
      pad_value <= '0;
      flat_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (tvs_pkg::cfg_reg_t'(cfg_index))
        tvs_pkg::REG_LOWER_X: lower_x   <= $signed(cfg_data);
        tvs_pkg::REG_UPPER_X: upper_x   <= $signed(cfg_data);
        tvs_pkg::REG_LOWER_Y: lower_y   <= $signed(cfg_data);
        tvs_pkg::REG_UPPER_Y: upper_y   <= $signed(cfg_data);
        tvs_pkg::REG_LOWER_Z: lower_z   <= $signed(cfg_data);
        tvs_pkg::REG_UPPER_Z: upper_z   <= $signed(cfg_data);
        tvs_pkg::REG_PAD:     pad_value <= $signed(cfg_data);
        tvs_pkg::REG_FLAT:    flat_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline valids and enables.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en_o;

  assign en_o = !out_valid || !out_stall;
  assign en4  = !v4 || en_o;
  assign en3  = !v3 || en4;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign in_stall = !en1;

  logic accept, load_acc, samp_acc;
  assign accept   = in_valid && !in_stall;
  assign load_acc = accept && (func == tvs_pkg::FUNC_LOAD) &&
                    (int'(load_col) < DIM_X) && (int'(load_row) < DIM_Y) &&
                    (int'(load_slice) < DIM_Z);
  assign samp_acc = accept && (func == tvs_pkg::FUNC_SAMPLE);

  // Load side: bank by parity, address by halved index.
  logic [2:0]    wr_bank;
  logic [AW-1:0] wr_addr;
  logic [BW-1:0] wr_word;

  assign wr_bank = {load_slice[0], load_row[0], load_col[0]};
  assign wr_addr = {AZW'(load_slice[5:1]), AYW'(load_row[5:1]), AXW'(load_col[5:1])};
  assign wr_word = {load_grad_z, load_grad_y, load_grad_x, load_level};

  // Sample side: split coordinates, check bounds, form bank addresses.
  logic signed [15:0] ia, ib, ic, icz;
  logic               ok0, flat0;
  logic [AXW-1:0]     hx [2];
  logic [AYW-1:0]     hy [2];
  logic [AZW-1:0]     hz [2];
  logic [FRAC_BITS-1:0] fz0;

  always_comb begin
    flat0 = flat_mode;
    ia  = coord_x >>> FRAC_BITS;
    ib  = coord_y >>> FRAC_BITS;
    ic  = coord_z >>> FRAC_BITS;
    icz = flat0 ? 16'sd0 : ic;
    fz0 = flat0 ? '0 : coord_z[FRAC_BITS-1:0];
    ok0 = (coord_x > lower_x) && (coord_x < upper_x) &&
          (coord_y > lower_y) && (coord_y < upper_y) &&
          !ia[15] && (int'(ia) < DIM_X - 1) &&
          !ib[15] && (int'(ib) < DIM_Y - 1);
    if (!flat0) begin
      ok0 = ok0 && (coord_z > lower_z) && (coord_z < upper_z) &&
            !ic[15] && (int'(ic) < DIM_Z - 1);
    end
    hx[0] = ia[AXW:1] + AXW'(ia[0]);
    hx[1] = ia[AXW:1];
    hy[0] = ib[AYW:1] + AYW'(ib[0]);
    hy[1] = ib[AYW:1];
    hz[0] = icz[AZW:1] + AZW'(icz[0]);
    hz[1] = icz[AZW:1];
  end

  // Eight parity banks: all neighbours are read in the same cycle.
  logic [BW-1:0] rd_data [8];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [BW-1:0] mem [DEPTH];
    logic [AW-1:0] rd_addr;
    assign rd_addr = {hz[b/4], hy[(b/2)%2], hx[b%2]};
    always_ff @(posedge clk) begin
      if (load_acc && wr_bank == 3'(b)) begin
        mem[wr_addr] <= wr_word;
      end
      if (samp_acc) begin
        rd_data[b] <= mem[rd_addr];
      end
    end
  end

  // Stage 1 side information.
  logic [FRAC_BITS-1:0] f1x, f1y, f1z;
  logic                 p1x, p1y, p1z, ok1, flat1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= samp_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (samp_acc) begin
      f1x   <= coord_x[FRAC_BITS-1:0];
      f1y   <= coord_y[FRAC_BITS-1:0];
      f1z   <= fz0;
      p1x   <= ia[0];
      p1y   <= ib[0];
      p1z   <= icz[0];
      ok1   <= ok0;
      flat1 <= flat0;
    end
  end

  // Stage 2: blend along x.
  logic signed [WX-1:0] lx_next [4][2][2];
  logic signed [WX-1:0] lx      [4][2][2];
  logic [FRAC_BITS-1:0] f2y, f2z;
  logic                 ok2, flat2;

  always_comb begin
    logic [2:0]               bi0, bi1;
    logic signed [VW-1:0]     d0, d1;
    logic signed [FRAC_BITS+1:0] w0, w1;
    w0 = $signed({1'b0, ONE - {1'b0, f1x}});
    w1 = $signed({2'b00, f1x});
    for (int k = 0; k < 4; k++) begin
      for (int dy = 0; dy < 2; dy++) begin
        for (int dz = 0; dz < 2; dz++) begin
          bi0 = {p1z ^ dz[0], p1y ^ dy[0], p1x};
          bi1 = {p1z ^ dz[0], p1y ^ dy[0], !p1x};
          d0  = $signed(rd_data[bi0][VW*k +: VW]);
          d1  = $signed(rd_data[bi1][VW*k +: VW]);
          lx_next[k][dy][dz] = d0 * w0 + d1 * w1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      lx    <= lx_next;
      f2y   <= f1y;
      f2z   <= f1z;
      ok2   <= ok1;
      flat2 <= flat1;
    end
  end

  // Stage 3: blend along y.
  logic signed [WY-1:0] ly_next [4][2];
  logic signed [WY-1:0] ly      [4][2];
  logic [FRAC_BITS-1:0] f3z;
  logic                 ok3, flat3;

  always_comb begin
    logic signed [FRAC_BITS+1:0] w0, w1;
    w0 = $signed({1'b0, ONE - {1'b0, f2y}});
    w1 = $signed({2'b00, f2y});
    for (int k = 0; k < 4; k++) begin
      for (int dz = 0; dz < 2; dz++) begin
        ly_next[k][dz] = lx[k][0][dz] * w0 + lx[k][1][dz] * w1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      ly    <= ly_next;
      f3z   <= f2z;
      ok3   <= ok2;
      flat3 <= flat2;
    end
  end

  // Stage 4: blend along z; in flat mode the upper slice carries no weight.
  logic signed [WZ-1:0] lz_next [4];
  logic signed [WZ-1:0] lz      [4];
  logic                 ok4, flat4;

  always_comb begin
    logic signed [FRAC_BITS+1:0] w0, w1;
    logic signed [WY-1:0]        upper;
    w0 = $signed({1'b0, ONE - {1'b0, f3z}});
    w1 = $signed({2'b00, f3z});
    for (int k = 0; k < 4; k++) begin
      upper = flat3 ? '0 : ly[k][1];
      lz_next[k] = ly[k][0] * w0 + upper * w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      lz    <= lz_next;
      ok4   <= ok3;
      flat4 <= flat3;
    end
  end

  // Round half up, saturate, select padding.
  logic signed [VW-1:0] rz [4];

  always_comb begin
    logic [WZ:0]        rs;
    logic signed [WZ-SH:0] q;
    for (int k = 0; k < 4; k++) begin
      rs = {lz[k][WZ-1], lz[k]} + HALF;
      q  = $signed(rs[WZ:SH]);
      if (q > $signed((WZ - SH + 1)'(32767))) begin
        rz[k] = 16'sh7FFF;
      end else if (q < -$signed((WZ - SH + 1)'(32768))) begin
        rz[k] = -16'sh8000;
      end else begin
        rz[k] = q[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_o) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && v4) begin
      inside_res <= ok4;
      level_out  <= ok4 ? rz[0] : pad_value;
      slope_x    <= ok4 ? rz[1] : '0;
      slope_y    <= ok4 ? rz[2] : '0;
      slope_z    <= (ok4 && !flat4) ? rz[3] : '0;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && v1 && v4))
    else $error("input stalled while the pipeline has room");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !inside_res) |-> (slope_x == 0 && slope_y == 0 && slope_z == 0))
    else $error("gradients not zero for an outside sample");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (v4 && en_o) |=> out_valid)
    else $error("result lost between last stage and output register");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Trilinear volume sampler testbench
// Loads voxels and sends sample coordinates through the input channel. A
// predictor of its own works out each interpolated result, and every beat
// that leaves the output channel is checked against the oldest expectation.
// The run steps through several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              func;
    logic [5:0]        col;
    logic [5:0]        row;
    logic [5:0]        slc;
    logic signed [15:0] lvl;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
  } beat_t;

  typedef struct packed {
    logic signed [15:0] lvl;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] sz;
    logic               ins;
  } sample_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  beat_t cur = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] level_out, slope_x, slope_y, slope_z;
  logic inside_res;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  beat_t queued_beats[$];
  sample_t expected_samples[$];
  logic signed [15:0] voxel_level[int], voxel_gx[int], voxel_gy[int], voxel_gz[int];
  bit loaded[int];
  int lo_x = 0, hi_x = 16128, lo_y = 0, hi_y = 16128, lo_z = 0, hi_z = 16128;
  int pad = 0;
  bit flat = 0;
  int idle_pct = 0, stall_pct = 0;
  int fails = 0;

  trilinear_volume_sampler u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .func(cur.func), .load_col(cur.col), .load_row(cur.row), .load_slice(cur.slc),
    .load_level(cur.lvl), .load_grad_x(cur.gx), .load_grad_y(cur.gy),
    .load_grad_z(cur.gz), .coord_x(cur.cx), .coord_y(cur.cy), .coord_z(cur.cz),
    .out_valid(out_valid), .out_stall(out_stall), .level_out(level_out),
    .slope_x(slope_x), .slope_y(slope_y), .slope_z(slope_z), .inside_res(inside_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int voxel_key(int x, int y, int z);
    return (z * 64 + y) * 64 + x;
  endfunction

  // A sample is interpolated only inside the strict bounds and with every
  // neighbour within the volume.
  function automatic bit within_reach(beat_t b);
    int ax, ay, az;
    bit ok;
    ax = int'(b.cx) >>> 8;
    ay = int'(b.cy) >>> 8;
    az = int'(b.cz) >>> 8;
    ok = b.cx > lo_x && b.cx < hi_x && b.cy > lo_y && b.cy < hi_y;
    ok = ok && ax >= 0 && ax + 1 < 64 && ay >= 0 && ay + 1 < 64;
    if (!flat) ok = ok && b.cz > lo_z && b.cz < hi_z && az >= 0 && az + 1 < 64;
    return ok;
  endfunction

  function automatic logic signed [15:0] round_sat(longint acc);
    longint q;
    q = (acc + (64'sd1 <<< 23)) >>> 24;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic sample_t predict_sample(beat_t b);
    int ax, ay, az, fx, fy, fz, dx, dy, dz, wz, key;
    longint w;
    longint acc[4];
    sample_t r;
    if (!within_reach(b)) begin
      r = '{lvl: pad[15:0], sx: '0, sy: '0, sz: '0, ins: 1'b0};
      return r;
    end
    ax = int'(b.cx) >>> 8;
    ay = int'(b.cy) >>> 8;
    az = flat ? 0 : int'(b.cz) >>> 8;
    fx = int'(b.cx) & 255;
    fy = int'(b.cy) & 255;
    fz = int'(b.cz) & 255;
    acc = '{0, 0, 0, 0};
    for (int n = 0; n < 8; n++) begin
      dx = n & 1;
      dy = (n >> 1) & 1;
      dz = (n >> 2) & 1;
      if (flat) wz = dz ? 0 : 256;
      else wz = dz ? fz : 256 - fz;
      w = longint'(dx ? fx : 256 - fx) * longint'(dy ? fy : 256 - fy) * wz;
      if (w != 0) begin
        key = voxel_key(ax + dx, ay + dy, az + dz);
        acc[0] += longint'(voxel_level[key]) * w;
        acc[1] += longint'(voxel_gx[key]) * w;
        acc[2] += longint'(voxel_gy[key]) * w;
        acc[3] += longint'(voxel_gz[key]) * w;
      end
    end
    r.lvl = round_sat(acc[0]);
    r.sx = round_sat(acc[1]);
    r.sy = round_sat(acc[2]);
    r.sz = flat ? 16'sd0 : round_sat(acc[3]);
    r.ins = 1'b1;
    return r;
  endfunction

  task automatic take_beat(beat_t b);
    int key;
    key = voxel_key(int'(b.col), int'(b.row), int'(b.slc));
    if (b.func == tvs_pkg::FUNC_LOAD) begin
      voxel_level[key] = b.lvl;
      voxel_gx[key] = b.gx;
      voxel_gy[key] = b.gy;
      voxel_gz[key] = b.gz;
    end else begin
      expected_samples.push_back(predict_sample(b));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) take_beat(cur);
      if (!in_valid || !in_stall) begin
        if (queued_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur <= queued_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("result beat with no expectation waiting");
          fails++;
        end else begin
          sample_t e;
          e = expected_samples.pop_front();
          if (level_out !== e.lvl) begin
            $error("level_out expected %0d got %0d", e.lvl, level_out);
            fails++;
          end
          if (slope_x !== e.sx) begin
            $error("slope_x expected %0d got %0d", e.sx, slope_x);
            fails++;
          end
          if (slope_y !== e.sy) begin
            $error("slope_y expected %0d got %0d", e.sy, slope_y);
            fails++;
          end
          if (slope_z !== e.sz) begin
            $error("slope_z expected %0d got %0d", e.sz, slope_z);
            fails++;
          end
          if (inside_res !== e.ins) begin
            $error("inside_res expected %0d got %0d", e.ins, inside_res);
            fails++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic add_load(int x, int y, int z, logic [15:0] l, logic [15:0] a,
                          logic [15:0] b, logic [15:0] c);
    beat_t t;
    t = beat_t'($urandom);
    t.cx = 16'($urandom);
    t.cy = 16'($urandom);
    t.cz = 16'($urandom);
    t.func = tvs_pkg::FUNC_LOAD;
    t.col = 6'(x);
    t.row = 6'(y);
    t.slc = 6'(z);
    t.lvl = l;
    t.gx = a;
    t.gy = b;
    t.gz = c;
    loaded[voxel_key(x, y, z)] = 1'b1;
    queued_beats.push_back(t);
  endtask

  // Any neighbour not yet loaded is loaded with random data first.
  task automatic add_sample(int x, int y, int z);
    beat_t t;
    int ax, ay, az;
    t = beat_t'($urandom);
    t.lvl = 16'($urandom);
    t.gz = 16'($urandom);
    t.func = tvs_pkg::FUNC_SAMPLE;
    t.cx = 16'(x);
    t.cy = 16'(y);
    t.cz = 16'(z);
    if (within_reach(t)) begin
      ax = int'(t.cx) >>> 8;
      ay = int'(t.cy) >>> 8;
      az = flat ? 0 : int'(t.cz) >>> 8;
      for (int n = 0; n < (flat ? 4 : 8); n++)
        if (!loaded.exists(voxel_key(ax + (n & 1), ay + ((n >> 1) & 1), az + (n >> 2))))
          add_load(ax + (n & 1), ay + ((n >> 1) & 1), az + (n >> 2),
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    queued_beats.push_back(t);
  endtask

  task automatic wait_idle();
    while (queued_beats.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(tvs_pkg::cfg_reg_t r, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    case (r)
      tvs_pkg::REG_LOWER_X: lo_x = int'(signed'(v));
      tvs_pkg::REG_UPPER_X: hi_x = int'(signed'(v));
      tvs_pkg::REG_LOWER_Y: lo_y = int'(signed'(v));
      tvs_pkg::REG_UPPER_Y: hi_y = int'(signed'(v));
      tvs_pkg::REG_LOWER_Z: lo_z = int'(signed'(v));
      tvs_pkg::REG_UPPER_Z: hi_z = int'(signed'(v));
      tvs_pkg::REG_PAD:     pad = int'(signed'(v));
      tvs_pkg::REG_FLAT:    flat = v[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(int lo, int hi, int p, bit f);
    set_reg(tvs_pkg::REG_LOWER_X, 16'(lo));
    set_reg(tvs_pkg::REG_UPPER_X, 16'(hi));
    set_reg(tvs_pkg::REG_LOWER_Y, 16'(lo + int'($urandom_range(3))));
    set_reg(tvs_pkg::REG_UPPER_Y, 16'(hi - int'($urandom_range(3))));
    set_reg(tvs_pkg::REG_LOWER_Z, 16'(lo));
    set_reg(tvs_pkg::REG_UPPER_Z, 16'(hi));
    set_reg(tvs_pkg::REG_PAD, 16'(p));
    set_reg(tvs_pkg::REG_FLAT, 16'(f));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_load(0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    add_load(1, 0, 0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    add_load(63, 63, 63, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_sample(128, 128, 128);
    add_sample(1, 1, 1);
    add_sample(255, 255, 255);
    add_sample(0, 128, 128);
    add_sample(16128, 128, 128);
    add_sample(128, 128, 16127);
    add_sample(-32768, 32767, -1);
    add_sample(62 * 256 + 128, 62 * 256 + 200, 62 * 256 + 1);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  apply_setting(0, 16128, 32767, 0); end
        1: begin idle_pct = 72; stall_pct = 0;  apply_setting(-32768, 32767, -32768, 1); end
        2: begin
          idle_pct = 0;
          stall_pct = 72;
          apply_setting($urandom_range(700) - 300, $urandom_range(16383, 1200), $urandom, 0);
        end
        default: begin
          idle_pct = 38;
          stall_pct = 38;
          apply_setting(-32768, 32767, $urandom, 0);
        end
      endcase
      for (int k = 0; k < 70; k++) begin
        if (p == 1 && k == 35) wait_idle();
        r = $urandom_range(99);
        if (r < 10)
          add_load($urandom_range(63), $urandom_range(63), $urandom_range(63),
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 75)
          add_sample($urandom_range(512), $urandom_range(512),
                     flat ? $urandom_range(65535) - 32768 : $urandom_range(512));
        else if (r < 80)
          add_sample($urandom_range(16383), $urandom_range(16383), $urandom_range(16383));
        else
          add_sample($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                     $urandom_range(65535) - 32768);
      end
      wait_idle();
    end

    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
